// File: rtl/assert_macros.svh
// Assertion helpers for the RTL files; the table unit includes them.
// Each use expects signals named clk and rst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define SKTF_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("sktf invariant violated");

// A condition that must hold in the cycle after the trigger was seen.
`define SKTF_ASSERT_NEXT(label, trig, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (expr)) \
        else $error("sktf sequence violated");

`endif

// File: rtl/sktf_pkg.sv
package sktf_pkg;

    // Item operation codes.
    typedef enum logic
    {
        OP_INSERT = 1'b0,
        OP_LOOKUP = 1'b1
    } op_t;

    // Result status codes.
    typedef enum logic [1:0]
    {
        ST_INSERTED  = 2'd0,
        ST_FOUND     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    // Control states of the top level.
    typedef enum logic
    {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } state_t;

    // Status that a cell shows to its right-hand neighbor.
    typedef struct packed
    {
        logic valid;
        logic le;
    } cell_stat_t;

    // Fixed widths of the channel fields.
    localparam int unsigned IN_KEY_W    = 32;
    localparam int unsigned IN_DATA_W   = 32;
    localparam int unsigned OUT_DATA_W  = 32;
    localparam int unsigned OUT_COUNT_W = 7;

endpackage

// File: rtl/sktf_cmd_if.sv
interface sktf_cmd_if;
    import sktf_pkg::*;

    logic                 valid;
    logic                 ready;
    op_t                  op;
    logic [IN_KEY_W-1:0]  key;
    logic [IN_DATA_W-1:0] entry_data;

    modport source (output valid, output op, output key, output entry_data, input ready);
    modport sink   (input valid, input op, input key, input entry_data, output ready);
endinterface

// File: rtl/sktf_result_if.sv
interface sktf_result_if;
    import sktf_pkg::*;

    logic                   valid;
    logic                   ready;
    status_t                status;
    logic [OUT_DATA_W-1:0]  found_data;
    logic [OUT_COUNT_W-1:0] entry_count;
    logic [OUT_DATA_W-1:0]  largest_key_data;

    modport source (output valid, output status, output found_data, output entry_count,
                    output largest_key_data, input ready);
    modport sink   (input valid, input status, input found_data, input entry_count,
                    input largest_key_data, output ready);
endinterface

// File: rtl/sktf_cell.sv
module sktf_cell #(
    parameter int KEY_WIDTH  = 32,
    parameter int DATA_WIDTH = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   shift_en,
    input  logic [KEY_WIDTH-1:0]   new_key,
    input  logic [DATA_WIDTH-1:0]  new_data,
    input  sktf_pkg::cell_stat_t   left_stat,
    input  logic [KEY_WIDTH-1:0]   left_key,
    input  logic [DATA_WIDTH-1:0]  left_data,
    output sktf_pkg::cell_stat_t   stat,
    output logic [KEY_WIDTH-1:0]   key,
    output logic [DATA_WIDTH-1:0]  data
);
    import sktf_pkg::*;

    logic                  valid_reg;
    logic                  valid_next;
    logic [KEY_WIDTH-1:0]  key_reg;
    logic [KEY_WIDTH-1:0]  key_next;
    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;
    logic                  le;

    // A held entry whose key is not above the broadcast key stays in place.
    assign le = valid_reg && (key_reg <= new_key);

    // On insert, the first cell that does not stay takes the new pair and
    // every cell after it takes the entry of its left neighbor.
    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        data_next  = data_reg;
        if (shift_en && !le)
        begin
            if (left_stat.le)
            begin
                valid_next = 1'b1;
                key_next   = new_key;
                data_next  = new_data;
            end
            else
            begin
                valid_next = left_stat.valid;
                key_next   = left_key;
                data_next  = left_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Entry payload needs no reset; the valid flag guards it.
    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        data_reg <= data_next;
    end

    assign stat.valid = valid_reg;
    assign stat.le    = le;
    assign key        = key_reg;
    assign data       = data_reg;

endmodule

// File: rtl/sorted_key_table_floor_lookup_unit.sv
// Sorted key table with floor lookup.
// The cmd channel carries one item per handshake: an insert of a key and a
// data handle, or a floor lookup of a key. The result channel returns one item
// for each command: a status, on a found lookup the data of the greatest key
// not above the query (else zero), the entry count after the command and the
// data of the largest key. Entries live in a row of CAPACITY cells kept in
// ascending key order; every cell compares its key with the command key at
// once and, on insert, keeps its entry, takes the new pair or takes its left
// neighbor's, so the table shifts open. Each command is captured in S_IDLE;
// in S_EXEC, once the result register is free, the cell row compares, shifts
// and loads the result register, and the state returns to S_IDLE. The result
// is registered, and a new command is taken only after the last one has left
// S_EXEC, so commands are handled one at a time.
// When the receiver stalls, the result register holds its item and one more
// command may be captured; that command waits, leaving the table untouched,
// until the result register frees.
// Reset empties every cell and clears the count; no clearing pass is needed.
`include "assert_macros.svh"

module sorted_key_table_floor_lookup_unit #(
    parameter int CAPACITY   = 64,
    parameter int KEY_WIDTH  = 32,
    parameter int DATA_WIDTH = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    sktf_cmd_if.sink      cmd,
    sktf_result_if.source result
);
    import sktf_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    state_t                 state_reg;
    state_t                 state_next;
    op_t                    op_reg;
    op_t                    op_next;
    logic [KEY_WIDTH-1:0]   key_reg;
    logic [KEY_WIDTH-1:0]   key_next;
    logic [DATA_WIDTH-1:0]  data_reg;
    logic [DATA_WIDTH-1:0]  data_next;
    logic [CW-1:0]          count_reg;
    logic [CW-1:0]          count_next;

    logic                   out_valid_reg;
    logic                   out_valid_next;
    status_t                out_status_reg;
    status_t                out_status_next;
    logic [DATA_WIDTH-1:0]  out_found_reg;
    logic [DATA_WIDTH-1:0]  out_found_next;
    logic [CW-1:0]          out_count_reg;
    logic [CW-1:0]          out_count_next;
    logic [DATA_WIDTH-1:0]  out_largest_reg;
    logic [DATA_WIDTH-1:0]  out_largest_next;

    logic                   exec_fire;
    logic                   full;
    logic                   shift_en;

    cell_stat_t             cell_stat [CAPACITY];
    logic [KEY_WIDTH-1:0]   cell_key  [CAPACITY];
    logic [DATA_WIDTH-1:0]  cell_data [CAPACITY];
    logic [CAPACITY:0]      le_ext;
    logic [CAPACITY:0]      valid_ext;
    logic [CAPACITY-1:0]    valid_vec;

    logic [DATA_WIDTH-1:0]  floor_data;
    logic                   floor_any;
    logic [DATA_WIDTH-1:0]  tail_data;
    logic                   tail_le;
    logic                   at_end;

    // Control signals.
    assign exec_fire = (state_reg == S_EXEC) && (!out_valid_reg || result.ready);
    assign full      = (count_reg == CW'(CAPACITY));
    assign shift_en  = exec_fire && (op_reg == OP_INSERT) && !full;

    // Cell row: cell zero sees a left neighbor that always lets the new pair in.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        if (i == 0)
        begin : g_first
            sktf_cell #(
                .KEY_WIDTH  (KEY_WIDTH),
                .DATA_WIDTH (DATA_WIDTH)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .shift_en  (shift_en),
                .new_key   (key_reg),
                .new_data  (data_reg),
                .left_stat ('{valid: 1'b1, le: 1'b1}),
                .left_key  ('0),
                .left_data ('0),
                .stat      (cell_stat[i]),
                .key       (cell_key[i]),
                .data      (cell_data[i])
            );
        end
        else
        begin : g_rest
            sktf_cell #(
                .KEY_WIDTH  (KEY_WIDTH),
                .DATA_WIDTH (DATA_WIDTH)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .shift_en  (shift_en),
                .new_key   (key_reg),
                .new_data  (data_reg),
                .left_stat (cell_stat[i-1]),
                .left_key  (cell_key[i-1]),
                .left_data (cell_data[i-1]),
                .stat      (cell_stat[i]),
                .key       (cell_key[i]),
                .data      (cell_data[i])
            );
        end
        assign le_ext[i]    = cell_stat[i].le;
        assign valid_ext[i] = cell_stat[i].valid;
    end

    assign le_ext[CAPACITY]    = 1'b0;
    assign valid_ext[CAPACITY] = 1'b0;
    assign valid_vec           = valid_ext[CAPACITY-1:0];

    // The floor entry is the last cell that stays; the tail is the last valid
    // cell. Both are one-hot, so their data is picked with an OR of masks.
    always_comb
    begin
        floor_data = '0;
        floor_any  = 1'b0;
        tail_data  = '0;
        tail_le    = 1'b0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            floor_data = floor_data |
                ({DATA_WIDTH{le_ext[i] && !le_ext[i+1]}} & cell_data[i]);
            floor_any  = floor_any | (le_ext[i] && !le_ext[i+1]);
            tail_data  = tail_data |
                ({DATA_WIDTH{valid_ext[i] && !valid_ext[i+1]}} & cell_data[i]);
            tail_le    = tail_le | (valid_ext[i] && !valid_ext[i+1] && le_ext[i]);
        end
    end

    // The new pair becomes the largest when it lands after every held entry.
    assign at_end = tail_le || (count_reg == '0);

    // Next state, command capture and result register loading.
    always_comb
    begin
        state_next       = state_reg;
        op_next          = op_reg;
        key_next         = key_reg;
        data_next        = data_reg;
        count_next       = count_reg;
        out_valid_next   = out_valid_reg;
        out_status_next  = out_status_reg;
        out_found_next   = out_found_reg;
        out_count_next   = out_count_reg;
        out_largest_next = out_largest_reg;
        cmd.ready        = 1'b0;

        if (result.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                cmd.ready = 1'b1;
                if (cmd.valid)
                begin
                    op_next    = cmd.op;
                    key_next   = KEY_WIDTH'(cmd.key);
                    data_next  = DATA_WIDTH'(cmd.entry_data);
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (exec_fire)
                begin
                    out_valid_next   = 1'b1;
                    out_largest_next = tail_data;
                    out_found_next   = '0;
                    if (op_reg == OP_INSERT)
                    begin
                        if (full)
                        begin
                            out_status_next = ST_FULL;
                        end
                        else
                        begin
                            out_status_next = ST_INSERTED;
                            count_next      = count_reg + 1'b1;
                            if (at_end)
                            begin
                                out_largest_next = data_reg;
                            end
                        end
                    end
                    else if (floor_any)
                    begin
                        out_status_next = ST_FOUND;
                        out_found_next  = floor_data;
                    end
                    else
                    begin
                        out_status_next = ST_NOT_FOUND;
                    end
                    out_count_next = count_next;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        key_reg         <= key_next;
        data_reg        <= data_next;
        out_status_reg  <= out_status_next;
        out_found_reg   <= out_found_next;
        out_count_reg   <= out_count_next;
        out_largest_reg <= out_largest_next;
    end

    // Result channel.
    assign result.valid            = out_valid_reg;
    assign result.status           = out_status_reg;
    assign result.found_data       = OUT_DATA_W'(out_found_reg);
    assign result.entry_count      = OUT_COUNT_W'(out_count_reg);
    assign result.largest_key_data = OUT_DATA_W'(out_largest_reg);

    // The count tracks the occupied cells, which always form a prefix.
    `SKTF_ASSERT_ALWAYS(a_count_bound, count_reg <= CW'(CAPACITY))
    `SKTF_ASSERT_ALWAYS(a_count_cells, $countones(valid_vec) == int'(count_reg))
    `SKTF_ASSERT_ALWAYS(a_cells_packed, ((valid_vec + CAPACITY'(1)) & valid_vec) == '0)
    `SKTF_ASSERT_NEXT(a_insert_grows, shift_en, count_reg == $past(count_reg) + 1'b1)

endmodule
